// File: src/sliding_window_average_filter_assert.svh
// assertion macros for the sliding window average filter
// expects clk and arst_n in the scope of the including module

`ifndef SLIDING_WINDOW_AVERAGE_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_FILTER_ASSERT_SVH

// same-cycle implication
`define SWAF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWAF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/swaf_pkg.sv
// shared types and constants of the sliding window average filter
// no dependencies

package swaf_pkg;

	localparam int DEF_MAX_WINDOW  = 16;
	localparam int DEF_SAMPLE_BITS = 12;

	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_LENGTH,
		REG_LIMIT,
		REG_WTS_OLD,
		REG_WTS_NEW
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_TRIM,
		MODE_LIMIT,
		MODE_WEIGHT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	localparam logic [4:0]  RST_LENGTH  = 5'd8;
	localparam logic [11:0] RST_LIMIT   = 12'hfff;
	localparam logic [63:0] RST_WEIGHTS = 64'h0101_0101_0101_0101;

endpackage

// File: src/swaf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// no package dependencies

module swaf_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic             fits;
	logic [DEN_W:0]   trial;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: src/sliding_window_average_filter.sv
// Sliding window average filter. Each sample request is pushed into a shift window and one
// result request gives the rounded plain, trimmed, step limited or weighted mean of the newest
// window_length entries. The time to a result is set by the window scan through the single
// multiply-accumulate unit, one entry a cycle, followed by the bit-serial divider, one quotient
// bit a cycle. A new sample is not taken before the result of the last one has been loaded
// into the output register. Weighted mode with a zero weight sum skips the divider.
// sample_stall stays high from acceptance until the result has been loaded into the output
// register. A result may wait there while the next sample is taken. Configuration is through
// an APB-style port with 64-bit registers at byte offsets 8*i.
// depends on swaf_pkg, swaf_div and sliding_window_average_filter_assert.svh

`include "sliding_window_average_filter_assert.svh"

module sliding_window_average_filter #(
	parameter int MAX_WINDOW  = swaf_pkg::DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = swaf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swaf_pkg::PADDR_W-1:0]  paddr,
	input  logic [swaf_pkg::PDATA_W-1:0]  pwdata,
	output logic [swaf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [SAMPLE_BITS-1:0]        filtered,
	output logic                          sample_held,
	output logic                          weight_fault
);

	import swaf_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int CL_W  = (LEN_W > 5) ? LEN_W : 5;
	localparam int ACC_W = SAMPLE_BITS + 8 + $clog2(MAX_WINDOW);
	localparam int DEN_W = 8 + $clog2(MAX_WINDOW);
	localparam int CMP_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
	localparam int PRD_W = SAMPLE_BITS + 8;

	// configuration registers
	mode_t       mode_q;
	logic [4:0]  length_q;
	logic [11:0] limit_q;
	logic [63:0] wts_old_q;
	logic [63:0] wts_new_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			length_q  <= RST_LENGTH;
			limit_q   <= RST_LIMIT;
			wts_old_q <= RST_WEIGHTS;
			wts_new_q <= RST_WEIGHTS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MODE:    mode_q    <= mode_t'(pwdata[1:0]);
				REG_LENGTH:  length_q  <= pwdata[4:0];
				REG_LIMIT:   limit_q   <= pwdata[11:0];
				REG_WTS_OLD: wts_old_q <= pwdata;
				REG_WTS_NEW: wts_new_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MODE:    prdata = {62'd0, mode_q};
			REG_LENGTH:  prdata = {59'd0, length_q};
			REG_LIMIT:   prdata = {52'd0, limit_q};
			REG_WTS_OLD: prdata = wts_old_q;
			REG_WTS_NEW: prdata = wts_new_q;
			default:     prdata = '0;
		endcase
	end

	// effective window length
	logic [CL_W-1:0]  len_wide;
	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] first_c;

	always_comb begin
		len_wide = CL_W'(length_q);
		if (len_wide < CL_W'(3))
			len_wide = CL_W'(3);
		else if (len_wide > CL_W'(MAX_WINDOW))
			len_wide = CL_W'(MAX_WINDOW);
		len_c   = LEN_W'(len_wide);
		first_c = LEN_W'(MAX_WINDOW) - len_c;
	end

	// sequencer
	state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] win_q [MAX_WINDOW];
	logic [IDX_W-1:0]       idx_q;
	logic [ACC_W-1:0]       acc_q;
	logic [DEN_W-1:0]       wsum_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic                   held_q;
	logic                   fault_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic                   rv_q;
	logic [SAMPLE_BITS-1:0] out_filt_q;
	logic                   out_held_q;
	logic                   out_fault_q;

	logic accept;
	logic scan_last;
	logic zero_wsum;
	logic div_start;
	logic div_done;
	logic out_load;

	logic [ACC_W-1:0] div_quo;
	logic [ACC_W-1:0] dividend_c;
	logic [DEN_W-1:0] divisor_c;

	assign accept    = sample_valid && !sample_stall;
	assign scan_last = LEN_W'(idx_q) == len_c - 1'b1;
	assign zero_wsum = (mode_q == MODE_WEIGHT) && (wsum_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		div_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				if (zero_wsum) begin
					state_d = ST_FINISH;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rv_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// step limit on the incoming sample
	logic [SAMPLE_BITS-1:0] last_s;
	logic [SAMPLE_BITS-1:0] diff_s;
	logic                   hold_c;
	logic [SAMPLE_BITS-1:0] push_s;

	assign last_s = win_q[MAX_WINDOW-1];
	assign diff_s = (sample > last_s) ? (sample - last_s) : (last_s - sample);
	assign hold_c = (mode_q == MODE_LIMIT) && (CMP_W'(diff_s) > CMP_W'(limit_q));
	assign push_s = hold_c ? last_s : sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++)
				win_q[i] <= '0;
		end else if (accept) begin
			for (int i = 0; i < MAX_WINDOW - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[MAX_WINDOW-1] <= push_s;
		end
	end

	// shared multiply-accumulate over the window
	logic [LEN_W-1:0]       pos_c;
	logic [SAMPLE_BITS-1:0] rd_c;
	logic [IDX_W+3:0]       idx_ext;
	logic [127:0]           wts_all;
	logic [7:0]             wt_c;
	logic [7:0]             mul_c;
	logic [PRD_W-1:0]       prod_c;

	assign pos_c   = first_c + LEN_W'(idx_q);
	assign rd_c    = win_q[pos_c[IDX_W-1:0]];
	assign idx_ext = (IDX_W + 4)'(idx_q);
	assign wts_all = {wts_new_q, wts_old_q};
	assign wt_c    = (idx_ext < (IDX_W + 4)'(16)) ? wts_all[{idx_ext[3:0], 3'b000} +: 8] : 8'd0;
	assign mul_c   = (mode_q == MODE_WEIGHT) ? wt_c : 8'd1;
	assign prod_c  = PRD_W'(rd_c) * PRD_W'(mul_c);

	// operands for the divider
	logic [LEN_W-1:0] trim_len;

	assign trim_len = len_c - LEN_W'(2);

	always_comb begin
		case (mode_q)
			MODE_WEIGHT: begin
				divisor_c  = wsum_q;
				dividend_c = acc_q + ACC_W'(wsum_q >> 1);
			end
			MODE_TRIM: begin
				divisor_c  = DEN_W'(trim_len);
				dividend_c = acc_q - ACC_W'(hi_q) - ACC_W'(lo_q) + ACC_W'(trim_len >> 1);
			end
			default: begin
				divisor_c  = DEN_W'(len_c);
				dividend_c = acc_q + ACC_W'(len_c >> 1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= '0;
			acc_q  <= '0;
			wsum_q <= '0;
			hi_q   <= '0;
			lo_q   <= '1;
			held_q <= hold_c;
		end else if (state_q == ST_SCAN) begin
			idx_q  <= idx_q + 1'b1;
			acc_q  <= acc_q + ACC_W'(prod_c);
			wsum_q <= wsum_q + DEN_W'(wt_c);
			if (rd_c > hi_q)
				hi_q <= rd_c;
			if (rd_c < lo_q)
				lo_q <= rd_c;
		end
		if (state_q == ST_PREP) begin
			fault_q <= zero_wsum;
			res_q   <= '0;
		end else if (div_done) begin
			res_q <= div_quo[SAMPLE_BITS-1:0];
		end
	end

	swaf_div #(
		.NUM_W (ACC_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_c),
		.divisor  (divisor_c),
		.done     (div_done),
		.quotient (div_quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_q <= 1'b0;
		else if (out_load)
			rv_q <= 1'b1;
		else if (!result_stall)
			rv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_filt_q  <= res_q;
			out_held_q  <= held_q;
			out_fault_q <= fault_q;
		end
	end

	assign result_valid = rv_q;
	assign filtered     = out_filt_q;
	assign sample_held  = out_held_q;
	assign weight_fault = out_fault_q;

	`SWAF_ASSERT_NXT(a_accept_scan, accept, state_q == ST_SCAN, "accepted sample did not start scan")
	`SWAF_ASSERT_IMP(a_scan_range, state_q == ST_SCAN, LEN_W'(idx_q) < len_c, "scan index past window")
	`SWAF_ASSERT_IMP(a_div_state, div_done, state_q == ST_DIVIDE, "divider finished outside divide")
	`SWAF_ASSERT_IMP(a_fault_zero, rv_q && out_fault_q, out_filt_q == '0, "fault with nonzero result")
	`SWAF_ASSERT_IMP(a_flag_excl, rv_q, !(out_held_q && out_fault_q), "both mode flags set")

endmodule
